### hdl/cse_pkg.sv
package cse_pkg;

    localparam int MaxResults = 5;
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    localparam logic [31:0] Cp1Max   = 32'h0000_007F;
    localparam logic [31:0] RawMax   = 32'h0000_00FF;
    localparam logic [31:0] Cp2Max   = 32'h0000_07FF;
    localparam logic [31:0] Cp3Max   = 32'h0000_FFFF;
    localparam logic [31:0] SurrLo   = 32'h0000_D800;
    localparam logic [31:0] SurrHi   = 32'h0000_DFFF;
    localparam logic [31:0] CpMax    = 32'h0010_FFFF;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  Lead4    = 8'hF0;
    localparam logic [7:0]  ContMark = 8'h80;
    localparam logic [7:0]  ContMask = 8'h3F;

    typedef enum logic [2:0] {
        ST_BYTE    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_BADHEX  = 3'd3,
        ST_UNSUP   = 3'd4,
        ST_SURR    = 3'd5,
        ST_RANGE   = 3'd6,
        ST_UNTERM  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_ESC    = 3'd1,
        M_OCT    = 3'd2,
        M_HEXX   = 3'd3,
        M_U4     = 3'd4,
        M_U8     = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } entry_t;

    // One command holds every result word caused by one input byte.
    typedef struct packed {
        entry_t [MaxResults-1:0] ent;
        logic [2:0]              count;
    } cmd_t;

    typedef struct packed {
        entry_t [3:0] ent;
        logic [2:0]   n;
        logic         ok;
    } enc_t;

    // Encodes a code point as UTF-8, or gives one error entry. With raw8 set,
    // values up to 0xFF pass as a single byte.
    function automatic enc_t utf8_encode(input logic [31:0] cp, input logic raw8);
        enc_t e;
        e = '0;
        e.ok = 1'b1;
        if (cp <= Cp1Max || (raw8 && cp <= RawMax)) begin
            e.ent[0].data = cp[7:0];
            e.ent[0].status = ST_BYTE;
            e.n = 3'd1;
        end
        else if (cp <= Cp2Max) begin
            e.ent[0].data = Lead2 | {3'b000, cp[10:6]};
            e.ent[1].data = ContMark | (cp[7:0] & ContMask);
            e.ent[0].status = ST_BYTE;
            e.ent[1].status = ST_BYTE;
            e.n = 3'd2;
        end
        else if (cp <= Cp3Max) begin
            if (cp >= SurrLo && cp <= SurrHi) begin
                e.ent[0].status = ST_SURR;
                e.n = 3'd1;
                e.ok = 1'b0;
            end
            else begin
                e.ent[0].data = Lead3 | {4'b0000, cp[15:12]};
                e.ent[1].data = ContMark | ({2'b00, cp[11:6]} & ContMask);
                e.ent[2].data = ContMark | (cp[7:0] & ContMask);
                e.ent[0].status = ST_BYTE;
                e.ent[1].status = ST_BYTE;
                e.ent[2].status = ST_BYTE;
                e.n = 3'd3;
            end
        end
        else if (cp <= CpMax) begin
            e.ent[0].data = Lead4 | {5'b00000, cp[20:18]};
            e.ent[1].data = ContMark | ({2'b00, cp[17:12]} & ContMask);
            e.ent[2].data = ContMark | ({2'b00, cp[11:6]} & ContMask);
            e.ent[3].data = ContMark | (cp[7:0] & ContMask);
            e.ent[0].status = ST_BYTE;
            e.ent[1].status = ST_BYTE;
            e.ent[2].status = ST_BYTE;
            e.ent[3].status = ST_BYTE;
            e.n = 3'd4;
        end
        else begin
            e.ent[0].status = ST_RANGE;
            e.n = 3'd1;
            e.ok = 1'b0;
        end
        return e;
    endfunction

endpackage

### hdl/cse_in_if.sv
interface cse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

### hdl/cse_out_if.sv
interface cse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

### hdl/c_string_escape_decoder.sv
// Decodes the body of a C string literal, one source word per cycle: the front
// end accepts a word in every cycle while its four-entry command queue has room,
// and the back end delivers one decoded word per cycle from its output register
// while the receiver is ready; a source word that expands into several results
// (at most five) holds the output until all of them are delivered. Bytes, simple,
// octal, hex and universal-character escapes all decode at this rate; the first
// result of a source word passes the command queue and then the output register.
module c_string_escape_decoder (
    input  logic      clk,
    input  logic      rst_n,
    cse_in_if.sink    in_ch,
    cse_out_if.source out_ch
);

    cse_pkg::cmd_t                cmd;
    cse_pkg::cmd_t                head;
    logic                         q_push;
    logic                         q_pop;
    logic                         q_empty;
    logic                         q_full;
    logic [cse_pkg::QCntW-1:0]    q_level;

    cse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .cmd_push (q_push),
        .cmd      (cmd)
    );

    cse_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full),
        .level    (q_level)
    );

    cse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .out_ch  (out_ch)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full && !q_pop))
        else $error("command queue written while full");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= cse_pkg::QCntW'(cse_pkg::QDepth))
        else $error("command queue level out of range");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != cse_pkg::ST_BYTE |-> out_ch.last
            && out_ch.out_byte == 8'd0)
        else $error("status word not final or carries a byte");

endmodule

### hdl/cse_front.sv
module cse_front (
    input  logic          clk,
    input  logic          rst_n,
    cse_in_if.sink        in_ch,
    input  logic          q_full,
    output logic          cmd_push,
    output cse_pkg::cmd_t cmd
);

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChApos   = 8'h27;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChQmark  = 8'h3F;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChSeven  = 8'h37;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowF   = 8'h66;
    localparam logic [7:0] ChUpA    = 8'h41;
    localparam logic [7:0] ChUpF    = 8'h46;
    localparam logic [7:0] ChLowN   = 8'h6E;
    localparam logic [7:0] ChLowR   = 8'h72;
    localparam logic [7:0] ChLowT   = 8'h74;
    localparam logic [7:0] ChLowB   = 8'h62;
    localparam logic [7:0] ChLowV   = 8'h76;
    localparam logic [7:0] ChLowX   = 8'h78;
    localparam logic [7:0] ChLowU   = 8'h75;
    localparam logic [7:0] ChUpU    = 8'h55;

    cse_pkg::mode_t   mode_reg, mode_next;
    logic [31:0]      accum_reg, accum_next;
    logic [3:0]       digits_reg, digits_next;

    logic             accept;
    logic             eoi;
    logic [7:0]       c;
    logic             hex_ok;
    logic [3:0]       hex_val;
    logic             oct_ok;
    logic [31:0]      hex_shift;
    logic [31:0]      cp_sel;
    cse_pkg::enc_t    enc;
    cse_pkg::enc_t    lead;
    logic             lead_enc_en;
    logic             lead_one_en;
    cse_pkg::entry_t  lead_one;
    logic             nb_en;
    logic             unterm_en;
    logic             trail_en;
    cse_pkg::entry_t  trail;
    logic             trail_ok;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !q_full;
    assign eoi = in_ch.end_of_input;
    assign c = in_ch.in_byte;

    always_comb
    begin
        hex_ok = 1'b0;
        hex_val = 4'd0;
        if (!eoi && c >= ChZero && c <= ChNine)
        begin
            hex_ok = 1'b1;
            hex_val = 4'(c - ChZero);
        end
        else if (!eoi && c >= ChLowA && c <= ChLowF)
        begin
            hex_ok = 1'b1;
            hex_val = 4'(c - ChLowA + 8'd10);
        end
        else if (!eoi && c >= ChUpA && c <= ChUpF)
        begin
            hex_ok = 1'b1;
            hex_val = 4'(c - ChUpA + 8'd10);
        end
    end

    assign oct_ok = !eoi && c >= ChZero && c <= ChSeven;
    assign hex_shift = {accum_reg[27:0], hex_val};
    assign cp_sel = (mode_reg == cse_pkg::M_HEXX) ? accum_reg : hex_shift;
    assign enc = cse_pkg::utf8_encode(cp_sel, mode_reg == cse_pkg::M_HEXX);

    always_comb
    begin
        mode_next = mode_reg;
        accum_next = accum_reg;
        digits_next = digits_reg;
        lead_enc_en = 1'b0;
        lead_one_en = 1'b0;
        lead_one = '0;
        nb_en = 1'b0;
        unterm_en = 1'b0;
        case (mode_reg)
            cse_pkg::M_ESC:
            begin
                mode_next = cse_pkg::M_NORMAL;
                accum_next = '0;
                digits_next = '0;
                lead_one_en = 1'b1;
                lead_one.status = cse_pkg::ST_BYTE;
                if (eoi)
                begin
                    lead_one.status = cse_pkg::ST_TRUNC;
                end
                else
                begin
                    case (c)
                        ChBslash, ChQuote, ChApos, ChQmark: lead_one.data = c;
                        ChLowN: lead_one.data = 8'h0A;
                        ChLowR: lead_one.data = 8'h0D;
                        ChLowT: lead_one.data = 8'h09;
                        ChLowB: lead_one.data = 8'h08;
                        ChLowF: lead_one.data = 8'h0C;
                        ChLowV: lead_one.data = 8'h0B;
                        ChLowA: lead_one.data = 8'h07;
                        ChLowX:
                        begin
                            lead_one_en = 1'b0;
                            mode_next = cse_pkg::M_HEXX;
                        end
                        ChLowU:
                        begin
                            lead_one_en = 1'b0;
                            mode_next = cse_pkg::M_U4;
                        end
                        ChUpU:
                        begin
                            lead_one_en = 1'b0;
                            mode_next = cse_pkg::M_U8;
                        end
                        default:
                        begin
                            if (oct_ok)
                            begin
                                lead_one_en = 1'b0;
                                mode_next = cse_pkg::M_OCT;
                                accum_next = {29'd0, c[2:0]};
                                digits_next = 4'd1;
                            end
                            else
                            begin
                                lead_one.status = cse_pkg::ST_UNSUP;
                            end
                        end
                    endcase
                end
            end
            cse_pkg::M_OCT:
            begin
                lead_one.status = cse_pkg::ST_BYTE;
                if (oct_ok)
                begin
                    accum_next = {accum_reg[28:0], c[2:0]};
                    digits_next = digits_reg + 4'd1;
                    if (digits_reg >= 4'd2)
                    begin
                        lead_one_en = 1'b1;
                        lead_one.data = accum_next[7:0];
                        mode_next = cse_pkg::M_NORMAL;
                        accum_next = '0;
                        digits_next = '0;
                    end
                end
                else
                begin
                    lead_one_en = 1'b1;
                    lead_one.data = accum_reg[7:0];
                    mode_next = cse_pkg::M_NORMAL;
                    accum_next = '0;
                    digits_next = '0;
                    unterm_en = eoi;
                    nb_en = !eoi;
                end
            end
            cse_pkg::M_HEXX:
            begin
                if (hex_ok)
                begin
                    accum_next = hex_shift;
                    if (digits_reg != 4'd15)
                    begin
                        digits_next = digits_reg + 4'd1;
                    end
                end
                else
                begin
                    mode_next = cse_pkg::M_NORMAL;
                    accum_next = '0;
                    digits_next = '0;
                    if (digits_reg == 4'd0)
                    begin
                        lead_one_en = 1'b1;
                        lead_one.status = cse_pkg::ST_BADHEX;
                    end
                    else
                    begin
                        lead_enc_en = 1'b1;
                        unterm_en = eoi;
                        nb_en = !eoi;
                    end
                end
            end
            cse_pkg::M_U4, cse_pkg::M_U8:
            begin
                if (eoi || !hex_ok)
                begin
                    mode_next = cse_pkg::M_NORMAL;
                    accum_next = '0;
                    digits_next = '0;
                    lead_one_en = 1'b1;
                    lead_one.status = eoi ? cse_pkg::ST_TRUNC : cse_pkg::ST_BADHEX;
                end
                else
                begin
                    accum_next = hex_shift;
                    digits_next = digits_reg + 4'd1;
                    if ((mode_reg == cse_pkg::M_U4 && digits_reg == 4'd3)
                        || (mode_reg == cse_pkg::M_U8 && digits_reg == 4'd7))
                    begin
                        mode_next = cse_pkg::M_NORMAL;
                        accum_next = '0;
                        digits_next = '0;
                        lead_enc_en = 1'b1;
                    end
                end
            end
            default:
            begin
                mode_next = cse_pkg::M_NORMAL;
                accum_next = '0;
                digits_next = '0;
                unterm_en = eoi;
                nb_en = !eoi;
            end
        endcase

        // A failed hex escape drops the byte that ended it.
        trail_ok = !lead_enc_en || enc.ok;
        trail_en = 1'b0;
        trail = '0;
        if (trail_ok && unterm_en)
        begin
            trail_en = 1'b1;
            trail.status = cse_pkg::ST_UNTERM;
        end
        else if (trail_ok && nb_en)
        begin
            if (c == ChQuote)
            begin
                trail_en = 1'b1;
                trail.status = cse_pkg::ST_CLOSED;
            end
            else if (c == ChBslash)
            begin
                mode_next = cse_pkg::M_ESC;
            end
            else
            begin
                trail_en = 1'b1;
                trail.data = c;
                trail.status = cse_pkg::ST_BYTE;
            end
        end

        lead = '0;
        if (lead_enc_en)
        begin
            lead = enc;
        end
        else if (lead_one_en)
        begin
            lead.ent[0] = lead_one;
            lead.n = 3'd1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < cse_pkg::MaxResults; i++)
        begin
            if (i < 4 && 3'(i) < lead.n)
            begin
                cmd.ent[i] = lead.ent[i % 4];
            end
            else
            begin
                cmd.ent[i] = trail;
            end
        end
        cmd.count = lead.n + {2'b00, trail_en};
    end

    assign cmd_push = accept && (cmd.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cse_pkg::M_NORMAL;
            accum_reg <= '0;
            digits_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            accum_reg <= accum_next;
            digits_reg <= digits_next;
        end
    end

endmodule

### hdl/cse_queue.sv
module cse_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  cse_pkg::cmd_t                push_cmd,
    input  logic                         pop,
    output cse_pkg::cmd_t                head,
    output logic                         empty,
    output logic                         full,
    output logic [cse_pkg::QCntW-1:0]    level
);

    cse_pkg::cmd_t                slot_reg [cse_pkg::QDepth];
    logic [cse_pkg::QPtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cse_pkg::QPtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cse_pkg::QCntW-1:0]    cnt_reg, cnt_next;

    assign head = slot_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == cse_pkg::QCntW'(cse_pkg::QDepth));
    assign level = cnt_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/cse_back.sv
module cse_back (
    input  logic          clk,
    input  logic          rst_n,
    input  cse_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    cse_out_if.source     out_ch
);

    logic               valid_reg, valid_next;
    logic [2:0]         idx_reg, idx_next;
    cse_pkg::entry_t    word_reg;
    logic               last_reg;
    logic               load;
    logic               take;
    logic               is_last;

    assign load = !valid_reg || out_ch.ready;
    assign take = load && !q_empty;
    assign is_last = (idx_reg == head.count - 3'd1);
    assign pop = take && is_last;

    always_comb
    begin
        valid_next = load ? !q_empty : valid_reg;
        idx_next = idx_reg;
        if (take)
        begin
            idx_next = is_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= head.ent[idx_reg];
            last_reg <= is_last;
        end
    end

    assign out_ch.valid = valid_reg;
    assign out_ch.out_byte = word_reg.data;
    assign out_ch.status = word_reg.status;
    assign out_ch.last = last_reg;

endmodule
